### rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on clk, off while arst_n is low
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
	`ASSERT_ALWAYS(label, (ante) |-> (cons), msg)

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	`ASSERT_ALWAYS(label, (ante) |=> (cons), msg)

`endif

### rtl/core/crfd_pkg.sv
package crfd_pkg;

	// field widths
	localparam int BYTE_W     = 8;
	localparam int CH_W       = 11;
	localparam int NUM_CH     = 8;
	localparam int PAYLOAD_W  = NUM_CH * CH_W;
	localparam int TDATA_W    = 96;
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 1;

	// frame bytes kept for decoding: length, type and the packed channels
	localparam int BUF_LAST   = 13;
	localparam int FIRST_DATA = 3;

	// frame codes
	localparam logic [BYTE_W-1:0] SYNC_A  = 8'hEE;
	localparam logic [BYTE_W-1:0] SYNC_B  = 8'hC8;
	localparam logic [BYTE_W-1:0] TYPE_RC = 8'h16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TOGGLE_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ON_LEVEL     = 1'b1;

	// configuration reset values
	localparam logic [7:0]      THRESHOLD_RESET = 8'd5;
	localparam logic [CH_W-1:0] ON_LEVEL_RESET  = 11'd1000;

	// completed frame as handed from front to back
	typedef struct packed {
		logic [BYTE_W-1:0]    ftype;
		logic [PAYLOAD_W-1:0] payload;
	} snap_t;

	// queue status seen by the two sides
	typedef struct packed {
		logic full;
		logic valid;
	} q_status_t;

endpackage

### rtl/core/crfd_front.sv
module crfd_front
	import crfd_pkg::*;
#(
	parameter int MAX_FRAME = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,
	input  q_status_t         q_stat,
	output logic              push,
	output snap_t             push_snap
);

	localparam int IDX_W = $clog2(MAX_FRAME);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_FRAME - 1);

	logic [IDX_W-1:0]  idx_q;
	logic [BYTE_W-1:0] buf_q [1:BUF_LAST];
	logic [BYTE_W-1:0] cur   [2:BUF_LAST];
	logic              fire;
	logic              take;
	logic [BYTE_W-1:0] len;
	logic              done;

	assign s_tready = !q_stat.full;

	// byte classification and frame completion
	always_comb begin
		fire = s_tvalid && s_tready;
		take = fire && !((idx_q == '0) && !(s_tdata inside {SYNC_A, SYNC_B}));
		len  = (idx_q == IDX_W'(1)) ? s_tdata : buf_q[1];
		done = take && (idx_q != '0) && (({1'b0, len} + 9'd1) == 9'(idx_q));
	end

	// frame view including the byte of this transfer
	always_comb begin
		for (int k = 2; k <= BUF_LAST; k++) begin
			cur[k] = (idx_q == IDX_W'(k)) ? s_tdata : buf_q[k];
		end
		push_snap.ftype = cur[2];
		for (int k = FIRST_DATA; k <= BUF_LAST; k++) begin
			push_snap.payload[(k - FIRST_DATA) * BYTE_W +: BYTE_W] = cur[k];
		end
		push = done;
	end

	// byte position within the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			if (done || idx_q == IDX_LAST) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// stored header and channel bytes, stale bytes stay for short frames
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= BUF_LAST; k++) begin
				buf_q[k] <= '0;
			end
		end else if (take) begin
			for (int k = 1; k <= BUF_LAST; k++) begin
				if (idx_q == IDX_W'(k)) begin
					buf_q[k] <= s_tdata;
				end
			end
		end
	end

endmodule

### rtl/core/crfd_queue.sv
module crfd_queue
	import crfd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  snap_t     push_snap,
	input  logic      pop,
	output snap_t     head,
	output q_status_t q_stat
);

	snap_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign head         = mem_q[rd_q];
	assign q_stat.full  = (cnt_q == 2'd2);
	assign q_stat.valid = (cnt_q != 2'd0);

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_snap;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

### rtl/core/crfd_back.sv
module crfd_back
	import crfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  q_status_t            q_stat,
	input  snap_t                head,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TDATA_W-1:0]   m_tdata,
	output logic                 m_tuser
);

	logic [7:0]           thr_q;
	logic [CH_W-1:0]      lvl_q;
	logic [PAYLOAD_W-1:0] chan_q;
	logic                 motor_q;
	logic [7:0]           cnt_q;
	logic                 vld_q;
	logic [TDATA_W-1:0]   data_q;
	logic                 rc_q;

	logic                 is_rc;
	logic [PAYLOAD_W-1:0] chans;
	logic                 want;
	logic                 disagree;
	logic [7:0]           cnt_inc;
	logic                 tog;
	logic                 motor_nxt;

	assign m_tvalid = vld_q;
	assign m_tdata  = data_q;
	assign m_tuser  = rc_q;
	assign pop      = q_stat.valid && (!vld_q || m_tready);

	// channel unpack and debounce decision
	always_comb begin
		is_rc     = (head.ftype == TYPE_RC);
		chans     = is_rc ? head.payload : chan_q;
		want      = (head.payload[PAYLOAD_W-1 -: CH_W] >= lvl_q);
		disagree  = is_rc && (want != motor_q);
		cnt_inc   = cnt_q + 8'd1;
		tog       = disagree && (cnt_inc >= thr_q);
		motor_nxt = tog ? want : motor_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
			lvl_q <= ON_LEVEL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOGGLE_LIMIT: thr_q <= cfg_wdata[7:0];
				REG_ON_LEVEL:     lvl_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// channel registers and motor debounce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q  <= '0;
			motor_q <= 1'b0;
			cnt_q   <= '0;
		end else if (pop) begin
			chan_q  <= chans;
			motor_q <= motor_nxt;
			if (tog) begin
				cnt_q <= '0;
			end else if (disagree) begin
				cnt_q <= cnt_inc;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (pop) begin
			vld_q <= 1'b1;
		end else if (m_tready) begin
			vld_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= {{(TDATA_W - PAYLOAD_W - 2){1'b0}}, tog, motor_nxt, chans};
			rc_q   <= is_rc;
		end
	end

endmodule

### rtl/core/crsf_rc_frame_decoder.sv
// channel  dir  width  fields (lowest bit first)
// s_*      in   8      tdata: rx_byte
// m_*      out  96/1   tdata: chan0..chan7, motor_on, motor_toggled, zero fill; tuser: is_rc_frame
// cfg_*    in   1/11   index 0 toggle_limit, index 1 on_level
//
// one byte is taken every cycle while the frame queue is not full; a completed frame passes
// through the two-entry frame queue and the output register of the back end on its way to m_*
// arst_n clears the frame position, stored header bytes, channels, motor state and queue
// s_tready drops only while the frame queue is full because m_tready is held low

module crsf_rc_frame_decoder
	import crfd_pkg::*;
#(
	parameter int MAX_FRAME = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [BYTE_W-1:0]    s_tdata,   // rx_byte
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TDATA_W-1:0]   m_tdata,   // chan0..chan7, motor_on, motor_toggled, zeros
	output logic                 m_tuser,   // is_rc_frame
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic      push;
	snap_t     push_snap;
	logic      pop;
	snap_t     head;
	q_status_t q_stat;

	// byte assembly
	crfd_front #(
		.MAX_FRAME(MAX_FRAME)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_stat    (q_stat),
		.push      (push),
		.push_snap (push_snap)
	);

	// completed frames in flight
	crfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_snap (push_snap),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	// decode, debounce and result register
	crfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_stat    (q_stat),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

### rtl/core/crfd_checker.sv
`include "assert_macros.svh"

module crfd_checker
	import crfd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic               m_tuser
);

	logic                 out_fire;
	logic                 prev_motor_q;
	logic [PAYLOAD_W-1:0] prev_chan_q;

	assign out_fire = m_tvalid && m_tready;

	// last delivered motor state and channels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_motor_q <= 1'b0;
			prev_chan_q  <= '0;
		end else if (out_fire) begin
			prev_motor_q <= m_tdata[PAYLOAD_W];
			prev_chan_q  <= m_tdata[PAYLOAD_W-1:0];
		end
	end

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// only rc frames move the motor
	`ASSERT_IMPLY(a_toggle_rc, m_tvalid && m_tdata[PAYLOAD_W+1], m_tuser, "toggle on non-rc frame")

	// motor state changes exactly when flagged
	`ASSERT_IMPLY(a_toggle_match, out_fire, (m_tdata[PAYLOAD_W] != prev_motor_q) == m_tdata[PAYLOAD_W+1], "motor change and toggle flag disagree")

	// non-rc frames leave channels as they were
	`ASSERT_IMPLY(a_chan_keep, out_fire && !m_tuser, m_tdata[PAYLOAD_W-1:0] == prev_chan_q, "channels changed on non-rc frame")

endmodule

bind crsf_rc_frame_decoder crfd_checker u_checker (.*);

### tb/testbench.sv
module testbench;
	import crfd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_CAP = 64;
	localparam int SETTLE_CYCLES = 8;

	// one decoded frame as seen on the result stream
	typedef struct packed {
		logic                        is_rc;
		logic [NUM_CH-1:0][CH_W-1:0] ch;
		logic                        motor_on;
		logic                        toggled;
	} frame_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [BYTE_W-1:0]    s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic                 m_tuser;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	// stimulus and expectations
	logic [BYTE_W-1:0] rx_bytes_q[$];
	frame_result_t     frame_results_q[$];
	int                mismatch_count = 0;

	// handshake bookkeeping and idling control
	logic s_took = 1'b0;
	logic idle_s_on = 1'b1;
	logic idle_m_on = 1'b1;
	int   gap_left = 0;
	int   stall_left = 0;

	// decoder state mirror
	int          frame_pos = 0;
	logic [7:0]  frame_bytes [FRAME_CAP] = '{default: 8'h00};
	logic [10:0] chan_reg [NUM_CH] = '{default: 11'h000};
	logic        motor_state = 1'b0;
	logic [7:0]  disagree_cnt = 8'd0;
	logic [7:0]  threshold_cfg = THRESHOLD_RESET;
	logic [10:0] level_cfg = ON_LEVEL_RESET;

	crsf_rc_frame_decoder #(
		.MAX_FRAME(FRAME_CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// frame assembly, channel unpack and motor debounce for one received byte
	function automatic void decode_byte(input logic [7:0] b);
		frame_result_t res;
		logic [87:0]   packed_ch;
		logic          want;
		if (frame_pos == 0 && b != SYNC_A && b != SYNC_B)
			return;
		if (frame_pos < FRAME_CAP)
			frame_bytes[frame_pos] = b;
		frame_pos++;
		if (frame_pos >= 2 && frame_pos == int'(frame_bytes[1]) + 2) begin
			res.is_rc = (frame_bytes[2] == TYPE_RC);
			res.toggled = 1'b0;
			if (res.is_rc) begin
				for (int k = 0; k < 11; k++)
					packed_ch[8*k +: 8] = frame_bytes[FIRST_DATA + k];
				for (int k = 0; k < NUM_CH; k++)
					chan_reg[k] = packed_ch[CH_W*k +: CH_W];
				want = (chan_reg[7] >= level_cfg);
				if (want != motor_state) begin
					disagree_cnt = disagree_cnt + 8'd1;
					if (disagree_cnt >= threshold_cfg) begin
						motor_state = want;
						disagree_cnt = 8'd0;
						res.toggled = 1'b1;
					end
				end
			end
			for (int k = 0; k < NUM_CH; k++)
				res.ch[k] = chan_reg[k];
			res.motor_on = motor_state;
			frame_results_q.push_back(res);
			frame_pos = 0;
		end
		if (frame_pos >= FRAME_CAP)
			frame_pos = 0;
	endfunction

	function automatic void compare_field(input string name, input logic [CH_W-1:0] want,
		input logic [CH_W-1:0] got);
		if (want != got) begin
			$display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// monitor: result check, register writes and byte transfers at the rising edge
	always @(posedge clk) begin
		frame_result_t exp_res;
		s_took <= s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (frame_results_q.size() == 0) begin
					$display("%0t mismatch: expected no result, actual tdata %h tuser %b",
						$time, m_tdata, m_tuser);
					mismatch_count++;
				end else begin
					exp_res = frame_results_q.pop_front();
					compare_field("is_rc_frame", CH_W'(exp_res.is_rc), CH_W'(m_tuser));
					for (int k = 0; k < NUM_CH; k++)
						compare_field($sformatf("chan%0d", k), exp_res.ch[k],
							m_tdata[CH_W*k +: CH_W]);
					compare_field("motor_on", CH_W'(exp_res.motor_on),
						CH_W'(m_tdata[PAYLOAD_W]));
					compare_field("motor_toggled", CH_W'(exp_res.toggled),
						CH_W'(m_tdata[PAYLOAD_W+1]));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_TOGGLE_LIMIT: threshold_cfg = cfg_wdata[7:0];
					REG_ON_LEVEL: level_cfg = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				decode_byte(s_tdata);
		end
	end

	// byte source: next byte after each transfer, with random gaps
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || s_took)) begin
			if (gap_left != 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (idle_s_on && $urandom_range(0, 9) == 0) begin
				gap_left = $urandom_range(0, 16);
				s_tvalid <= 1'b0;
			end else if (rx_bytes_q.size() != 0) begin
				s_tdata <= rx_bytes_q.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result sink: random stall bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_m_on && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(0, 16);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_settings(input logic [7:0] thr, input logic [10:0] lvl,
		input logic [2:0] upper);
		write_reg(REG_TOGGLE_LIMIT, {upper, thr});
		write_reg(REG_ON_LEVEL, lvl);
	endtask

	function automatic logic [7:0] sync_byte();
		return ($urandom_range(0, 1) != 0) ? SYNC_A : SYNC_B;
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// frame with the given length; body fills bytes 3..13, later bytes random
	task automatic push_frame(input int len, input logic [7:0] ftype, input logic [87:0] body);
		rx_bytes_q.push_back(sync_byte());
		rx_bytes_q.push_back(8'(len));
		for (int i = 2; i < len + 2; i++) begin
			if (i == 2)
				rx_bytes_q.push_back(ftype);
			else if (i <= BUF_LAST)
				rx_bytes_q.push_back(body[8*(i-FIRST_DATA) +: 8]);
			else
				rx_bytes_q.push_back(rand_byte());
		end
	endtask

	// rc frame whose channel seven agrees or disagrees with the motor at random
	task automatic push_rc_frame(input int len);
		logic [87:0] body;
		logic [10:0] c7;
		for (int k = 0; k < NUM_CH - 1; k++)
			body[CH_W*k +: CH_W] = 11'($urandom_range(0, 2047));
		if ($urandom_range(0, 9) == 0 || level_cfg == 0)
			c7 = 11'($urandom_range(0, 2047));
		else if ($urandom_range(0, 1) != 0)
			c7 = 11'($urandom_range(level_cfg, 2047));
		else
			c7 = 11'($urandom_range(0, level_cfg - 1));
		body[CH_W*7 +: CH_W] = c7;
		push_frame(len, TYPE_RC, body);
	endtask

	// length that cannot fit: fills the buffer and is dropped
	task automatic push_overrun(input int len);
		rx_bytes_q.push_back(sync_byte());
		rx_bytes_q.push_back(8'(len));
		for (int i = 2; i < FRAME_CAP; i++)
			rx_bytes_q.push_back(rand_byte());
	endtask

	task automatic fill_random(input int budget);
		int target;
		int sel;
		int len;
		target = rx_bytes_q.size() + budget;
		while (rx_bytes_q.size() < target) begin
			sel = $urandom_range(0, 99);
			if (sel < 55) begin
				push_rc_frame(12);
			end else if (sel < 65) begin
				push_rc_frame(22);
			end else if (sel < 75) begin
				push_rc_frame($urandom_range(0, 62));
			end else if (sel < 85) begin
				push_frame($urandom_range(0, 30), rand_byte(),
					88'({$urandom(), $urandom(), $urandom()}));
			end else if (sel < 91) begin
				// line noise between frames
				repeat ($urandom_range(1, 6))
					rx_bytes_q.push_back(rand_byte());
			end else if (sel < 96) begin
				// truncated frame, later bytes are absorbed into it
				len = $urandom_range(3, 40);
				rx_bytes_q.push_back(sync_byte());
				rx_bytes_q.push_back(8'(len));
				repeat ($urandom_range(0, len - 1))
					rx_bytes_q.push_back(rand_byte());
			end else begin
				push_overrun($urandom_range(63, 255));
			end
		end
	endtask

	task automatic wait_drained();
		while (rx_bytes_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (frame_results_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// run limit
	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// dropped bytes, zero length, short rc frame, full-scale channels, stale type
		rx_bytes_q = '{8'h00, 8'hFF, SYNC_B, 8'h00, SYNC_A, 8'h01, TYPE_RC};
		push_frame(12, TYPE_RC, {88{1'b1}});
		push_frame(0, TYPE_RC, '0);
		push_frame(2, 8'h20, {80'h0, 8'h55});
		wait_drained();

		// threshold of one, lowest level, longest fitting and first overlong frame
		apply_settings(8'd1, 11'd0, 3'b000);
		push_rc_frame(62);
		push_overrun(63);
		fill_random(150);
		wait_drained();

		// highest threshold and level
		apply_settings(8'd255, 11'd2047, 3'b111);
		fill_random(225);
		wait_drained();

		// threshold lowered below the running count
		apply_settings(8'd4, 11'($urandom_range(0, 2047)), 3'b000);
		fill_random(225);
		wait_drained();

		// zero threshold, no idling
		idle_s_on = 1'b0;
		idle_m_on = 1'b0;
		apply_settings(8'd0, 11'($urandom_range(0, 2047)), 3'($urandom_range(0, 7)));
		fill_random(225);
		wait_drained();

		idle_s_on = 1'b1;
		apply_settings(8'($urandom_range(1, 8)), 11'($urandom_range(0, 2047)), 3'b000);
		fill_random(225);
		wait_drained();

		idle_s_on = 1'b0;
		idle_m_on = 1'b1;
		apply_settings(8'd3, 11'd1024, 3'b000);
		fill_random(225);
		wait_drained();

		// closing stretch without idling
		idle_m_on = 1'b0;
		apply_settings(8'($urandom_range(1, 6)), 11'($urandom_range(0, 2047)), 3'b000);
		fill_random(225);
		wait_drained();

		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
